[design/slcf_pkg.sv]
package slcf_pkg;

  localparam int unsigned CfgIndexWidth = 3;
  localparam int unsigned CfgDataWidth  = 16;

  typedef enum logic [CfgIndexWidth-1:0] {
    CFG_SYNC_FIRST    = 3'd0,
    CFG_SYNC_SECOND   = 3'd1,
    CFG_LENGTH_LIMIT  = 3'd2,
    CFG_CRC_POLY      = 3'd3,
    CFG_CRC_START     = 3'd4,
    CFG_CRC_LSB_FIRST = 3'd5
  } cfg_index_t;

  localparam logic [7:0]  SyncFirstReset   = 8'hAA;
  localparam logic [7:0]  SyncSecondReset  = 8'h55;
  localparam logic [7:0]  LengthLimitReset = 8'd64;
  localparam logic [15:0] CrcPolyReset     = 16'h1021;
  localparam logic [15:0] CrcStartReset    = 16'hFFFF;

  typedef enum logic [2:0] {
    PH_SYNC1   = 3'd0,
    PH_SYNC2   = 3'd1,
    PH_TYPE    = 3'd2,
    PH_LENGTH  = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_CRCLO   = 3'd5,
    PH_CRCHI   = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    ST_INCOMPLETE = 2'd0,
    ST_FRAME_OK   = 2'd1,
    ST_LENGTH_ERR = 2'd2,
    ST_CRC_ERR    = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0]  sync_first;
    logic [7:0]  sync_second;
    logic [7:0]  length_limit;
    logic [15:0] crc_poly;
    logic [15:0] crc_start;
    logic        crc_lsb_first;
  } cfg_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  frame_kind;
    logic [7:0]  frame_length;
    logic        data_valid;
    logic [7:0]  data_byte;
    logic [7:0]  data_index;
    logic [15:0] crc_seen;
  } result_t;

endpackage

[design/slcf_crc.sv]
module slcf_crc (
  input  logic [15:0] crc_in,
  input  logic [7:0]  data,
  input  logic [15:0] poly,
  input  logic        lsb_first,
  output logic [15:0] crc_out
);

  logic [15:0] poly_rev;
  logic [15:0] c;

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      poly_rev[i] = poly[15-i];
    end
  end

  // one byte, one bit per step
  always_comb begin
    if (lsb_first) begin
      c = crc_in ^ {8'h00, data};
      for (int i = 0; i < 8; i++) begin
        c = c[0] ? ((c >> 1) ^ poly_rev) : (c >> 1);
      end
    end else begin
      c = crc_in ^ {data, 8'h00};
      for (int i = 0; i < 8; i++) begin
        c = c[15] ? ((c << 1) ^ poly) : (c << 1);
      end
    end
    crc_out = c;
  end

endmodule

[design/slcf_parser.sv]
module slcf_parser (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic [7:0]           rx_byte,
  input  slcf_pkg::cfg_t       cfg,
  output slcf_pkg::result_t    result
);

  slcf_pkg::phase_t phase, phase_next;
  logic [7:0]  kind_reg, kind_reg_next;
  logic [7:0]  length_reg, length_reg_next;
  logic [7:0]  byte_count, byte_count_next;
  logic [15:0] crc_accum, crc_accum_next;
  logic [15:0] crc_received, crc_received_next;
  logic [15:0] crc_upd;
  logic [7:0]  count_inc;

  slcf_crc u_crc (
    .crc_in    (crc_accum),
    .data      (rx_byte),
    .poly      (cfg.crc_poly),
    .lsb_first (cfg.crc_lsb_first),
    .crc_out   (crc_upd)
  );

  assign count_inc = byte_count + 8'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= slcf_pkg::PH_SYNC1;
      kind_reg     <= '0;
      length_reg   <= '0;
      byte_count   <= '0;
      crc_accum    <= slcf_pkg::CrcStartReset;
      crc_received <= '0;
    end else if (step) begin
      phase        <= phase_next;
      kind_reg     <= kind_reg_next;
      length_reg   <= length_reg_next;
      byte_count   <= byte_count_next;
      crc_accum    <= crc_accum_next;
      crc_received <= crc_received_next;
    end
  end

  always_comb begin
    phase_next        = phase;
    kind_reg_next     = kind_reg;
    length_reg_next   = length_reg;
    byte_count_next   = byte_count;
    crc_accum_next    = crc_accum;
    crc_received_next = crc_received;
    result            = '0;
    result.status     = slcf_pkg::ST_INCOMPLETE;

    unique case (phase)
      slcf_pkg::PH_SYNC1: begin
        if (rx_byte == cfg.sync_first) phase_next = slcf_pkg::PH_SYNC2;
      end
      slcf_pkg::PH_SYNC2: begin
        if (rx_byte == cfg.sync_second) begin
          phase_next     = slcf_pkg::PH_TYPE;
          crc_accum_next = cfg.crc_start;
        end else if (rx_byte != cfg.sync_first) begin
          phase_next = slcf_pkg::PH_SYNC1;
        end
      end
      slcf_pkg::PH_TYPE: begin
        kind_reg_next  = rx_byte;
        crc_accum_next = crc_upd;
        phase_next     = slcf_pkg::PH_LENGTH;
      end
      slcf_pkg::PH_LENGTH: begin
        length_reg_next = rx_byte;
        byte_count_next = '0;
        if (rx_byte > cfg.length_limit) begin
          phase_next        = slcf_pkg::PH_SYNC1;
          crc_accum_next    = cfg.crc_start;
          crc_received_next = '0;
          result.status     = slcf_pkg::ST_LENGTH_ERR;
        end else begin
          crc_accum_next = crc_upd;
          phase_next = (rx_byte == 8'd0) ? slcf_pkg::PH_CRCLO : slcf_pkg::PH_PAYLOAD;
        end
      end
      slcf_pkg::PH_PAYLOAD: begin
        result.data_valid = 1'b1;
        result.data_byte  = rx_byte;
        result.data_index = byte_count;
        byte_count_next   = count_inc;
        crc_accum_next    = crc_upd;
        if (count_inc >= length_reg || count_inc == 8'd0) phase_next = slcf_pkg::PH_CRCLO;
      end
      slcf_pkg::PH_CRCLO: begin
        crc_received_next = {8'h00, rx_byte};
        phase_next        = slcf_pkg::PH_CRCHI;
      end
      slcf_pkg::PH_CRCHI: begin
        result.crc_seen   = {rx_byte, crc_received[7:0]};
        result.status     = ({rx_byte, crc_received[7:0]} == crc_accum) ?
                            slcf_pkg::ST_FRAME_OK : slcf_pkg::ST_CRC_ERR;
        phase_next        = slcf_pkg::PH_SYNC1;
        byte_count_next   = '0;
        crc_accum_next    = cfg.crc_start;
        crc_received_next = '0;
      end
      default: begin
        // illegal phase code: drop the byte and restart the hunt
        phase_next        = slcf_pkg::PH_SYNC1;
        byte_count_next   = '0;
        crc_accum_next    = cfg.crc_start;
        crc_received_next = '0;
      end
    endcase

    result.frame_kind   = kind_reg_next;
    result.frame_length = length_reg_next;
  end

endmodule

[design/sync_length_crc_frame_parser.sv]
// Sync/length/CRC-16 frame parser. Takes one received byte per request on the
// input channel and returns exactly one result per byte: status (incomplete,
// frame ok, length error, crc error), the current type and length bytes, the
// payload byte with its index when the byte was payload, and the received CRC
// on the byte that closes a frame. The frame state and the byte-wide CRC
// update sit in combinational logic ahead of a single output register, so a
// byte is accepted every cycle as long as the output side does not stall; a
// stalled, full output register stalls the input. Sync bytes, length limit,
// CRC polynomial, start value and bit order are set through the write port
// (indices 0..5), and writes should only be made while the block is idle.
module sync_length_crc_frame_parser (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [7:0]                         rx_byte,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [1:0]                         status,
  output logic [7:0]                         frame_kind,
  output logic [7:0]                         frame_length,
  output logic                               data_valid,
  output logic [7:0]                         data_byte,
  output logic [7:0]                         data_index,
  output logic [15:0]                        crc_seen,
  input  logic                               cfg_we,
  input  logic [slcf_pkg::CfgIndexWidth-1:0] cfg_index,
  input  logic [slcf_pkg::CfgDataWidth-1:0]  cfg_data
);

  slcf_pkg::cfg_t    cfg;
  slcf_pkg::result_t result, result_reg;
  logic              accept;

  assign in_stall = out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sync_first    <= slcf_pkg::SyncFirstReset;
      cfg.sync_second   <= slcf_pkg::SyncSecondReset;
      cfg.length_limit  <= slcf_pkg::LengthLimitReset;
      cfg.crc_poly      <= slcf_pkg::CrcPolyReset;
      cfg.crc_start     <= slcf_pkg::CrcStartReset;
      cfg.crc_lsb_first <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        slcf_pkg::CFG_SYNC_FIRST:    cfg.sync_first    <= cfg_data[7:0];
        slcf_pkg::CFG_SYNC_SECOND:   cfg.sync_second   <= cfg_data[7:0];
        slcf_pkg::CFG_LENGTH_LIMIT:  cfg.length_limit  <= cfg_data[7:0];
        slcf_pkg::CFG_CRC_POLY:      cfg.crc_poly      <= cfg_data;
        slcf_pkg::CFG_CRC_START:     cfg.crc_start     <= cfg_data;
        slcf_pkg::CFG_CRC_LSB_FIRST: cfg.crc_lsb_first <= cfg_data[0];
        default: ;
      endcase
    end
  end

  slcf_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .step    (accept),
    .rx_byte (rx_byte),
    .cfg     (cfg),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) result_reg <= result;
  end

  assign status       = result_reg.status;
  assign frame_kind   = result_reg.frame_kind;
  assign frame_length = result_reg.frame_length;
  assign data_valid   = result_reg.data_valid;
  assign data_byte    = result_reg.data_byte;
  assign data_index   = result_reg.data_index;
  assign crc_seen     = result_reg.crc_seen;

endmodule

[design/slcf_checker.sv]
module slcf_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  status,
  input logic        data_valid,
  input logic [7:0]  data_byte,
  input logic [7:0]  data_index,
  input logic [15:0] crc_seen
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(crc_seen)
                               && $stable(data_byte))
    else $error("stalled result changed");

  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted byte gave no result");

  a_payload_incomplete: assert property (@(posedge clk) disable iff (rst)
    out_valid && data_valid |-> status == slcf_pkg::ST_INCOMPLETE && crc_seen == 16'd0)
    else $error("payload byte with final status");

  a_crc_only_at_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != slcf_pkg::ST_FRAME_OK && status != slcf_pkg::ST_CRC_ERR
      |-> crc_seen == 16'd0)
    else $error("crc shown outside frame end");

  a_idle_data_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !data_valid |-> data_byte == 8'd0 && data_index == 8'd0)
    else $error("data fields set without payload");

endmodule

bind sync_length_crc_frame_parser slcf_checker u_slcf_checker (.*);

[tb/sv/tb.sv]
class frame_board;
  slcf_pkg::cfg_t     cfg;
  slcf_pkg::phase_t   phase;
  logic [7:0]         kind_q;
  logic [7:0]         len_q;
  logic [7:0]         count_q;
  logic [15:0]        crc_acc;
  logic [15:0]        crc_rx;
  slcf_pkg::result_t  awaited[$];
  int                 mismatches;
  int                 reports;
  int                 frames_ok;
  int                 crc_errs;
  int                 len_errs;
  int                 payload_seen;

  function new();
    cfg.sync_first    = slcf_pkg::SyncFirstReset;
    cfg.sync_second   = slcf_pkg::SyncSecondReset;
    cfg.length_limit  = slcf_pkg::LengthLimitReset;
    cfg.crc_poly      = slcf_pkg::CrcPolyReset;
    cfg.crc_start     = slcf_pkg::CrcStartReset;
    cfg.crc_lsb_first = 1'b0;
    kind_q = '0;
    len_q = '0;
    close_frame();
  endfunction

  function void close_frame();
    phase   = slcf_pkg::PH_SYNC1;
    count_q = '0;
    crc_acc = cfg.crc_start;
    crc_rx  = '0;
  endfunction

  function void write_reg(slcf_pkg::cfg_index_t idx, logic [15:0] v);
    case (idx)
      slcf_pkg::CFG_SYNC_FIRST:    cfg.sync_first = v[7:0];
      slcf_pkg::CFG_SYNC_SECOND:   cfg.sync_second = v[7:0];
      slcf_pkg::CFG_LENGTH_LIMIT:  cfg.length_limit = v[7:0];
      slcf_pkg::CFG_CRC_POLY:      cfg.crc_poly = v;
      slcf_pkg::CFG_CRC_START:     cfg.crc_start = v;
      slcf_pkg::CFG_CRC_LSB_FIRST: cfg.crc_lsb_first = v[0];
      default: ;
    endcase
  endfunction

  // byte-wide CRC-16 update, no final xor
  function logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] rpoly;
    logic [15:0] c;
    for (int i = 0; i < 16; i++) rpoly[i] = cfg.crc_poly[15-i];
    c = crc;
    if (cfg.crc_lsb_first) begin
      c = c ^ {8'h00, b};
      for (int i = 0; i < 8; i++) c = c[0] ? ((c >> 1) ^ rpoly) : (c >> 1);
    end else begin
      c = c ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) c = c[15] ? ((c << 1) ^ cfg.crc_poly) : (c << 1);
    end
    return c;
  endfunction

  function void note_byte(logic [7:0] b);
    slcf_pkg::result_t r;
    r = '0;
    r.status = slcf_pkg::ST_INCOMPLETE;
    case (phase)
      slcf_pkg::PH_SYNC1: begin
        if (b == cfg.sync_first) phase = slcf_pkg::PH_SYNC2;
      end
      slcf_pkg::PH_SYNC2: begin
        if (b == cfg.sync_second) begin
          phase = slcf_pkg::PH_TYPE;
          crc_acc = cfg.crc_start;
        end else if (b != cfg.sync_first) begin
          phase = slcf_pkg::PH_SYNC1;
        end
      end
      slcf_pkg::PH_TYPE: begin
        kind_q = b;
        crc_acc = crc_byte(crc_acc, b);
        phase = slcf_pkg::PH_LENGTH;
      end
      slcf_pkg::PH_LENGTH: begin
        len_q = b;
        count_q = '0;
        crc_acc = crc_byte(crc_acc, b);
        if (b > cfg.length_limit) begin
          close_frame();
          r.status = slcf_pkg::ST_LENGTH_ERR;
        end else if (b == 8'd0) begin
          phase = slcf_pkg::PH_CRCLO;
        end else begin
          phase = slcf_pkg::PH_PAYLOAD;
        end
      end
      slcf_pkg::PH_PAYLOAD: begin
        r.data_valid = 1'b1;
        r.data_byte = b;
        r.data_index = count_q;
        count_q = count_q + 8'd1;
        crc_acc = crc_byte(crc_acc, b);
        if (count_q >= len_q || count_q == 8'd0) phase = slcf_pkg::PH_CRCLO;
      end
      slcf_pkg::PH_CRCLO: begin
        crc_rx = {8'h00, b};
        phase = slcf_pkg::PH_CRCHI;
      end
      slcf_pkg::PH_CRCHI: begin
        crc_rx[15:8] = b;
        r.crc_seen = crc_rx;
        r.status = (crc_rx == crc_acc) ? slcf_pkg::ST_FRAME_OK : slcf_pkg::ST_CRC_ERR;
        close_frame();
      end
      default: close_frame();
    endcase
    r.frame_kind = kind_q;
    r.frame_length = len_q;
    awaited.push_back(r);
  endfunction

  function void cmp(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  function void check_report(logic [1:0] st, logic [7:0] kind, logic [7:0] len,
                             logic dv, logic [7:0] db, logic [7:0] di,
                             logic [15:0] seen);
    slcf_pkg::result_t e;
    if (awaited.size() == 0) begin
      $error("result with no byte pending: status %0d", st);
      mismatches++;
      return;
    end
    e = awaited.pop_front();
    reports++;
    case (e.status)
      slcf_pkg::ST_FRAME_OK:   frames_ok++;
      slcf_pkg::ST_CRC_ERR:    crc_errs++;
      slcf_pkg::ST_LENGTH_ERR: len_errs++;
      default: ;
    endcase
    if (e.data_valid) payload_seen++;
    cmp("status", e.status, st);
    cmp("frame_kind", e.frame_kind, kind);
    cmp("frame_length", e.frame_length, len);
    cmp("data_valid", e.data_valid, dv);
    cmp("data_byte", e.data_byte, db);
    cmp("data_index", e.data_index, di);
    cmp("crc_seen", e.crc_seen, seen);
  endfunction
endclass

module tb;

  typedef logic [7:0] byte_list_t[$];

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  rx_byte;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  status;
  logic [7:0]  frame_kind;
  logic [7:0]  frame_length;
  logic        data_valid;
  logic [7:0]  data_byte;
  logic [7:0]  data_index;
  logic [15:0] crc_seen;
  logic        cfg_we;
  logic [slcf_pkg::CfgIndexWidth-1:0] cfg_index;
  logic [slcf_pkg::CfgDataWidth-1:0]  cfg_data;

  frame_board board;
  int   bytes_sent = 0;
  int   send_idle_pct = 6;
  int   recv_idle_pct = 49;
  logic hold_req = 1'b0;

  sync_length_crc_frame_parser dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .frame_kind   (frame_kind),
    .frame_length (frame_length),
    .data_valid   (data_valid),
    .data_byte    (data_byte),
    .data_index   (data_index),
    .crc_seen     (crc_seen),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) board.note_byte(rx_byte);
      if (out_valid && !out_stall)
        board.check_report(status, frame_kind, frame_length, data_valid,
                           data_byte, data_index, crc_seen);
    end
  end

  // result side; long hold-off is counted here
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 40;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  initial begin
    #200000;
    $display("Test completed with failures");
    $finish;
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic push_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (board.awaited.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic set_reg(input slcf_pkg::cfg_index_t idx, input logic [15:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(negedge clk);
    board.write_reg(idx, v);
  endtask

  task automatic configure(input logic [7:0] s1, input logic [7:0] s2,
                           input logic [7:0] lim, input logic [15:0] poly,
                           input logic [15:0] start, input logic lsb);
    settle();
    set_reg(slcf_pkg::CFG_SYNC_FIRST, {8'h00, s1});
    set_reg(slcf_pkg::CFG_SYNC_SECOND, {8'h00, s2});
    set_reg(slcf_pkg::CFG_LENGTH_LIMIT, {8'h00, lim});
    set_reg(slcf_pkg::CFG_CRC_POLY, poly);
    set_reg(slcf_pkg::CFG_CRC_START, start);
    set_reg(slcf_pkg::CFG_CRC_LSB_FIRST, {15'h0000, lsb});
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // stops after the length byte when the body is over the limit
  task automatic send_frame(input logic [7:0] kind, input byte_list_t body,
                            input logic [15:0] crc_flip);
    logic [15:0] crc;
    logic [7:0]  len;
    len = 8'(body.size());
    crc = board.cfg.crc_start;
    push_byte(board.cfg.sync_first);
    push_byte(board.cfg.sync_second);
    push_byte(kind);
    crc = board.crc_byte(crc, kind);
    push_byte(len);
    crc = board.crc_byte(crc, len);
    if (len > board.cfg.length_limit) return;
    foreach (body[i]) begin
      push_byte(body[i]);
      crc = board.crc_byte(crc, body[i]);
    end
    crc = crc ^ crc_flip;
    push_byte(crc[7:0]);
    push_byte(crc[15:8]);
  endtask

  task automatic random_traffic(input int count);
    int         stop_at;
    int         pick;
    int         lim;
    int         len;
    byte_list_t body;
    stop_at = bytes_sent + count;
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(99);
      lim = board.cfg.length_limit;
      body = {};
      if (pick < 82) begin
        if (pick >= 74 && lim < 255) len = $urandom_range(255, lim + 1);
        else if ($urandom_range(9) == 0) len = $urandom_range(lim < 40 ? lim : 40);
        else len = $urandom_range(lim < 6 ? lim : 6);
        repeat (len) body.push_back(8'($urandom));
        if ($urandom_range(7) == 0) push_byte(board.cfg.sync_first);
        send_frame(8'($urandom), body,
                   (pick >= 64 && pick < 74) ? 16'($urandom_range(65535, 1)) : 16'h0000);
      end else if (pick < 91) begin
        // broken sequences: bad second sync or a truncated header
        push_byte(board.cfg.sync_first);
        if ($urandom_range(1) == 0) begin
          push_byte(8'($urandom));
        end else begin
          push_byte(board.cfg.sync_second);
          repeat ($urandom_range(4)) push_byte(8'($urandom));
        end
      end else begin
        repeat ($urandom_range(4, 1))
          push_byte(($urandom_range(2) == 0) ? board.cfg.sync_first : 8'($urandom));
      end
    end
  endtask

  initial begin
    byte_list_t body;
    board = new();
    rst = 1'b1;
    in_valid = 1'b0;
    rx_byte = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: repeated first sync and wrong second sync, empty frame, crc error,
    // extreme payload bytes, overlong length
    push_byte(slcf_pkg::SyncFirstReset);
    push_byte(slcf_pkg::SyncFirstReset);
    body = {};
    send_frame(8'h00, body, 16'h0000);
    push_byte(slcf_pkg::SyncFirstReset);
    push_byte(8'h12);
    body = {};
    body.push_back(8'h00);
    body.push_back(8'hFF);
    send_frame(8'hFF, body, 16'h0001);
    body = {};
    repeat (65) body.push_back(8'h5A);
    send_frame(8'h41, body, 16'h0000);

    random_traffic(90);
    settle();

    configure(8'h00, 8'hFF, 8'd0, 16'h8005, 16'h0000, 1'b1);
    random_traffic(90);

    send_idle_pct = 49;
    recv_idle_pct = 6;
    configure(8'hFF, 8'h00, 8'd255, 16'hFFFF, 16'hFFFF, 1'b0);
    random_traffic(90);
    body = {};
    repeat (255) body.push_back(8'($urandom));
    send_frame(8'($urandom), body, 16'h0000);

    configure(8'h7E, 8'h7E, 8'd16, 16'h0000, 16'h1D0F, 1'b1);
    random_traffic(90);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    configure(8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom),
              16'($urandom), 1'($urandom));
    hold_req = 1'b1;
    random_traffic(90);

    settle();
    $display("Sent %0d bytes over five register settings; %0d results checked.",
             bytes_sent, board.reports);
    $display("Frames ok %0d, crc errors %0d, length errors %0d, payload bytes %0d.",
             board.frames_ok, board.crc_errs, board.len_errs, board.payload_seen);
    if (board.mismatches == 0 && board.awaited.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
